>>> rtl/core/discrete_log_bsgs_defines.svh
// assertion macros used by the checker file
`ifndef DISCRETE_LOG_BSGS_DEFINES_SVH
`define DISCRETE_LOG_BSGS_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define DLB_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define DLB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/dlb_pkg.sv
`timescale 1ns / 1ps

package dlb_pkg;

   localparam int WORD_BITS  = 32;
   localparam int INDEX_BITS = 17;
   localparam int EPOCH_BITS = 8;
   localparam int ROOT_BITS  = 17;

   // multiplicative hash constant
   localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

   // one table entry: epoch tag marks it valid for the current query
   typedef struct packed {
      logic [EPOCH_BITS-1:0] epoch;
      logic [INDEX_BITS-1:0] index;
      logic [WORD_BITS-1:0]  residue;
   } entry_type;

   // modular multiplier: per-query constants
   typedef struct packed {
      logic [31:0] pn;     // modulus shifted up until bit 31 is set
      logic [32:0] mu;     // floor((2^64 - 1) / pn)
      logic [4:0]  shift;  // normalizing shift
   } mm_cfg_type;

   typedef struct packed {
      logic        start;
      logic [31:0] x;
      logic [31:0] y;
   } mm_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] value;
   } mm_rsp_type;

endpackage

>>> rtl/core/dlb_ram.sv
`timescale 1ns / 1ps

module dlb_ram #(
   parameter int WIDTH = 57,
   parameter int DEPTH = 131072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/core/dlb_modmul.sv
`timescale 1ns / 1ps

// x * y mod p by Barrett reduction against the normalized modulus
module dlb_modmul
   import dlb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  mm_cfg_type cfg,
   input  mm_req_type req,
   output mm_rsp_type rsp
);

   typedef enum logic [2:0] {
      MM_IDLE, MM_MUL, MM_SHIFT, MM_QUO, MM_QP, MM_SUB, MM_FIX
   } mm_state_type;

   mm_state_type state_ff, state_in;
   logic [31:0]  x_ff, x_in, y_ff, y_in;
   logic [63:0]  prod_ff, prod_in, xs_ff, xs_in;
   logic [65:0]  q2_ff, q2_in;
   logic [34:0]  qp_ff, qp_in, r_ff, r_in;
   logic         done_ff, done_in;
   logic [31:0]  result_ff, result_in;
   logic [64:0]  qp_full;

   always_comb begin
      state_in  = state_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      prod_in   = prod_ff;
      xs_in     = xs_ff;
      q2_in     = q2_ff;
      qp_in     = qp_ff;
      r_in      = r_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      qp_full   = {32'b0, q2_ff[65:33]} * {33'b0, cfg.pn};
      unique case (state_ff)
         MM_IDLE: begin
            if (req.start) begin
               x_in     = req.x;
               y_in     = req.y;
               state_in = MM_MUL;
            end
         end
         MM_MUL: begin
            prod_in  = {32'b0, x_ff} * {32'b0, y_ff};
            state_in = MM_SHIFT;
         end
         // scale so the reduction runs against pn
         MM_SHIFT: begin
            xs_in    = prod_ff << cfg.shift;
            state_in = MM_QUO;
         end
         // quotient estimate, at most three short
         MM_QUO: begin
            q2_in    = {33'b0, xs_ff[63:31]} * {33'b0, cfg.mu};
            state_in = MM_QP;
         end
         MM_QP: begin
            qp_in    = qp_full[34:0];
            state_in = MM_SUB;
         end
         MM_SUB: begin
            r_in     = xs_ff[34:0] - qp_ff;
            state_in = MM_FIX;
         end
         // subtract pn until in range, then undo the scaling
         MM_FIX: begin
            if (r_ff >= {3'b0, cfg.pn}) begin
               r_in = r_ff - {3'b0, cfg.pn};
            end else begin
               result_in = r_ff[31:0] >> cfg.shift;
               done_in   = 1'b1;
               state_in  = MM_IDLE;
            end
         end
         default: state_in = MM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      prod_ff   <= prod_in;
      xs_ff     <= xs_in;
      q2_ff     <= q2_in;
      qp_ff     <= qp_in;
      r_ff      <= r_in;
      result_ff <= result_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = result_ff;

endmodule

>>> rtl/core/discrete_log_bsgs.sv
`timescale 1ns / 1ps

// channel   direction  ports                                   word
// req       in         req_valid/req_ready                     base, target, modulus
// rsp       out        rsp_valid/rsp_ready                     found, exponent
//
// one query at a time, with up to m = ceil(sqrt(p)) baby steps and m giant steps;
// a query's run time is set by the serial chain of modular multiplies and the
// hash probes on the table memory
// after reset a clearing pass over all TABLE_SLOTS slots runs before the first word;
// the same pass runs after every 255 queries that use the table
// a result waiting in the output register does not stop the next request word
module discrete_log_bsgs
   import dlb_pkg::*;
#(
   parameter int MODULUS_BITS = 32,
   parameter int TABLE_SLOTS  = 131072
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_base,
   input  logic [31:0] req_target,
   input  logic [31:0] req_modulus,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [31:0] rsp_exponent
);

   localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
   localparam logic [31:0] IN_MASK = 32'((64'd1 << MODULUS_BITS) - 64'd1);
   localparam logic [32:0] RECIP = 33'((64'd1 << (32 + SLOT_BITS)) / TABLE_SLOTS);
   localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TABLE_SLOTS - 1);
   localparam logic [SLOT_BITS:0] SLOTS_W = (SLOT_BITS + 1)'(TABLE_SLOTS);

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_NORM, ST_DIV, ST_RED_A, ST_RED_B, ST_CHECK,
      ST_SQRT, ST_SQRT_FIX, ST_EPOCH, ST_BABY, ST_BABY_STEP, ST_BABY_MUL,
      ST_POW, ST_POW_ACC, ST_POW_SQ, ST_GIANT, ST_GIANT_STEP, ST_GIANT_MUL,
      ST_HASH1, ST_HASH2, ST_HASH3, ST_HASH4, ST_PROBE_RD, ST_PROBE_CHK,
      ST_MM_WAIT, ST_HIT, ST_FINISH
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   logic [31:0]           a_ff, a_in, b_ff, b_in, p_ff, p_in;
   logic [31:0]           pn_ff, pn_in, rem_ff, rem_in;
   logic [32:0]           quo_ff, quo_in;
   logic [4:0]            shift_ff, shift_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [ROOT_BITS-1:0]  root_ff, root_in, m_ff, m_in;
   logic [ROOT_BITS-1:0]  j_ff, j_in, i_ff, i_in;
   logic [31:0]           cur_ff, cur_in, g_ff, g_in;
   logic [31:0]           acc_ff, acc_in, sq_ff, sq_in, e_ff, e_in;
   logic [31:0]           key_ff, key_in, h_ff, h_in, q_ff, q_in;
   logic [SLOT_BITS:0]    diff_ff, diff_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in, n_ff, n_in, clr_ff, clr_in;
   logic                  clr_resume_ff, clr_resume_in, lookup_ff, lookup_in;
   logic [EPOCH_BITS-1:0] epoch_ff, epoch_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic                  mm_start_ff, mm_start_in;
   logic [31:0]           mm_x_ff, mm_x_in, mm_y_ff, mm_y_in;
   logic                  res_found_ff, res_found_in;
   logic [31:0]           res_exp_ff, res_exp_in;
   logic                  rsp_valid_ff, rsp_valid_in, rsp_found_ff, rsp_found_in;
   logic [31:0]           rsp_exp_ff, rsp_exp_in;

   // combinational helpers
   logic [31:0]            p_masked, pm1, qt, dt;
   logic [32:0]            rem_t;
   logic [ROOT_BITS-1:0]   sq_op;
   logic [2*ROOT_BITS-1:0] sq_prod;
   logic [64:0]            hq;
   logic [33:0]            im;
   logic                   ram_wr_en, ram_rd_en;
   logic [SLOT_BITS-1:0]   ram_wr_addr;
   entry_type              ram_wr_data, rd_entry;
   logic [$bits(entry_type)-1:0] ram_rd_data;
   logic                   slot_live, slot_match;
   mm_cfg_type             mm_cfg;
   mm_req_type             mm_req;
   mm_rsp_type             mm_rsp;

   assign p_masked   = req_modulus & IN_MASK;
   assign pm1        = p_ff - 32'd1;
   assign rem_t      = {rem_ff, 1'b1};
   assign sq_op      = (state_ff == ST_SQRT) ? (root_ff | (ROOT_BITS'(1) << cnt_ff[4:0]))
                                             : root_ff;
   assign sq_prod    = sq_op * sq_op;
   assign hq         = {32'b0, h_ff} * {32'b0, RECIP};
   assign qt         = 32'(q_ff * 32'(TABLE_SLOTS));
   assign dt         = h_ff - qt;
   assign im         = {17'b0, i_ff} * {17'b0, m_ff};
   assign rd_entry   = entry_type'(ram_rd_data);
   assign slot_live  = (rd_entry.epoch == epoch_ff);
   assign slot_match = (rd_entry.residue == key_ff);

   assign mm_cfg.pn    = pn_ff;
   assign mm_cfg.mu    = quo_ff;
   assign mm_cfg.shift = shift_ff;
   assign mm_req.start = mm_start_ff;
   assign mm_req.x     = mm_x_ff;
   assign mm_req.y     = mm_y_ff;

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      p_in          = p_ff;
      pn_in         = pn_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      shift_in      = shift_ff;
      cnt_in        = cnt_ff;
      root_in       = root_ff;
      m_in          = m_ff;
      j_in          = j_ff;
      i_in          = i_ff;
      cur_in        = cur_ff;
      g_in          = g_ff;
      acc_in        = acc_ff;
      sq_in         = sq_ff;
      e_in          = e_ff;
      key_in        = key_ff;
      h_in          = h_ff;
      q_in          = q_ff;
      diff_in       = diff_ff;
      slot_in       = slot_ff;
      n_in          = n_ff;
      clr_in        = clr_ff;
      clr_resume_in = clr_resume_ff;
      lookup_in     = lookup_ff;
      epoch_in      = epoch_ff;
      idx_in        = idx_ff;
      mm_start_in   = 1'b0;
      mm_x_in       = mm_x_ff;
      mm_y_in       = mm_y_ff;
      res_found_in  = res_found_ff;
      res_exp_in    = res_exp_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_found_in  = rsp_found_ff;
      rsp_exp_in    = rsp_exp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = slot_ff;
      ram_wr_data   = '{epoch: epoch_ff, index: j_ff, residue: key_ff};
      ram_rd_en     = 1'b0;

      unique case (state_ff)
         // sweep the table back to epoch zero
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + SLOT_BITS'(1);
            if (clr_ff == LAST_SLOT) begin
               clr_in = '0;
               if (clr_resume_ff) begin
                  clr_resume_in = 1'b0;
                  epoch_in      = EPOCH_BITS'(1);
                  state_in      = ST_BABY;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               a_in     = req_base & IN_MASK;
               b_in     = req_target & IN_MASK;
               p_in     = p_masked;
               pn_in    = p_masked;
               shift_in = '0;
               if (p_masked == 32'd0) begin
                  res_found_in = 1'b0;
                  res_exp_in   = 32'd0;
                  state_in     = ST_FINISH;
               end else begin
                  state_in = ST_NORM;
               end
            end
         end
         // normalize the modulus, one bit a cycle
         ST_NORM: begin
            if (pn_ff[31]) begin
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end else begin
               pn_in    = pn_ff << 1;
               shift_in = shift_ff + 5'd1;
            end
         end
         // restoring division of all ones by pn for the Barrett constant
         ST_DIV: begin
            if (rem_t >= {1'b0, pn_ff}) begin
               rem_in = 32'(rem_t - {1'b0, pn_ff});
               quo_in = {quo_ff[31:0], 1'b1};
            end else begin
               rem_in = rem_t[31:0];
               quo_in = {quo_ff[31:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               mm_start_in = 1'b1;
               mm_x_in     = a_ff;
               mm_y_in     = 32'd1;
               ret_in      = ST_RED_A;
               state_in    = ST_MM_WAIT;
            end
         end
         ST_RED_A: begin
            a_in        = mm_rsp.value;
            mm_start_in = 1'b1;
            mm_x_in     = b_ff;
            mm_y_in     = 32'd1;
            ret_in      = ST_RED_B;
            state_in    = ST_MM_WAIT;
         end
         ST_RED_B: begin
            b_in     = mm_rsp.value;
            state_in = ST_CHECK;
         end
         // trivial answers
         ST_CHECK: begin
            if (a_ff == 32'd0) begin
               res_found_in = (b_ff == 32'd0);
               res_exp_in   = {31'b0, b_ff == 32'd0};
               state_in     = ST_FINISH;
            end else if (b_ff == 32'd1) begin
               res_found_in = 1'b1;
               res_exp_in   = 32'd0;
               state_in     = ST_FINISH;
            end else begin
               root_in  = '0;
               cnt_in   = 6'(ROOT_BITS - 1);
               state_in = ST_SQRT;
            end
         end
         // integer square root, one bit a cycle
         ST_SQRT: begin
            if (sq_prod <= {2'b0, p_ff}) begin
               root_in = sq_op;
            end
            if (cnt_ff == 6'd0) begin
               state_in = ST_SQRT_FIX;
            end else begin
               cnt_in = cnt_ff - 6'd1;
            end
         end
         ST_SQRT_FIX: begin
            m_in     = (sq_prod < {2'b0, p_ff}) ? root_ff + ROOT_BITS'(1) : root_ff;
            state_in = ST_EPOCH;
         end
         // new epoch invalidates every entry at once; once the epoch is exhausted the table is swept first
         ST_EPOCH: begin
            j_in   = '0;
            cur_in = 32'd1;
            if (&epoch_ff) begin
               epoch_in      = '0;
               clr_in        = '0;
               clr_resume_in = 1'b1;
               state_in      = ST_CLEAR;
            end else begin
               epoch_in = epoch_ff + EPOCH_BITS'(1);
               state_in = ST_BABY;
            end
         end
         // baby steps
         ST_BABY: begin
            if (j_ff == m_ff) begin
               e_in     = (pm1 >= {15'b0, m_ff}) ? pm1 - {15'b0, m_ff} : 32'd0;
               acc_in   = 32'd1;
               sq_in    = a_ff;
               state_in = ST_POW;
            end else begin
               key_in    = cur_ff;
               lookup_in = 1'b0;
               state_in  = ST_HASH1;
            end
         end
         ST_BABY_STEP: begin
            mm_start_in = 1'b1;
            mm_x_in     = cur_ff;
            mm_y_in     = a_ff;
            ret_in      = ST_BABY_MUL;
            state_in    = ST_MM_WAIT;
         end
         ST_BABY_MUL: begin
            cur_in   = mm_rsp.value;
            j_in     = j_ff + ROOT_BITS'(1);
            state_in = ST_BABY;
         end
         // giant-step factor by square and multiply
         ST_POW: begin
            if (e_ff == 32'd0) begin
               i_in     = '0;
               g_in     = b_ff;
               state_in = ST_GIANT;
            end else begin
               mm_start_in = 1'b1;
               state_in    = ST_MM_WAIT;
               if (e_ff[0]) begin
                  mm_x_in = acc_ff;
                  mm_y_in = sq_ff;
                  ret_in  = ST_POW_ACC;
               end else begin
                  mm_x_in = sq_ff;
                  mm_y_in = sq_ff;
                  ret_in  = ST_POW_SQ;
               end
            end
         end
         ST_POW_ACC: begin
            acc_in      = mm_rsp.value;
            mm_start_in = 1'b1;
            mm_x_in     = sq_ff;
            mm_y_in     = sq_ff;
            ret_in      = ST_POW_SQ;
            state_in    = ST_MM_WAIT;
         end
         ST_POW_SQ: begin
            sq_in    = mm_rsp.value;
            e_in     = e_ff >> 1;
            state_in = ST_POW;
         end
         // giant steps
         ST_GIANT: begin
            if (i_ff == m_ff) begin
               res_found_in = 1'b0;
               res_exp_in   = 32'd0;
               state_in     = ST_FINISH;
            end else begin
               key_in    = g_ff;
               lookup_in = 1'b1;
               state_in  = ST_HASH1;
            end
         end
         ST_GIANT_STEP: begin
            mm_start_in = 1'b1;
            mm_x_in     = g_ff;
            mm_y_in     = acc_ff;
            ret_in      = ST_GIANT_MUL;
            state_in    = ST_MM_WAIT;
         end
         ST_GIANT_MUL: begin
            g_in     = mm_rsp.value;
            i_in     = i_ff + ROOT_BITS'(1);
            state_in = ST_GIANT;
         end
         // home slot: hash, then mod table size by reciprocal
         ST_HASH1: begin
            h_in     = key_ff * HASH_MULT;
            state_in = ST_HASH2;
         end
         ST_HASH2: begin
            q_in     = 32'(hq >> (32 + SLOT_BITS));
            state_in = ST_HASH3;
         end
         ST_HASH3: begin
            diff_in  = dt[SLOT_BITS:0];
            state_in = ST_HASH4;
         end
         ST_HASH4: begin
            slot_in  = (diff_ff >= SLOTS_W) ? SLOT_BITS'(diff_ff - SLOTS_W)
                                            : diff_ff[SLOT_BITS-1:0];
            n_in     = '0;
            state_in = ST_PROBE_RD;
         end
         ST_PROBE_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_PROBE_CHK;
         end
         // linear probing, read then decide
         ST_PROBE_CHK: begin
            if (!slot_live || slot_match) begin
               if (lookup_ff) begin
                  if (slot_live) begin
                     idx_in   = rd_entry.index;
                     state_in = ST_HIT;
                  end else begin
                     state_in = ST_GIANT_STEP;
                  end
               end else begin
                  ram_wr_en = !slot_live;
                  state_in  = ST_BABY_STEP;
               end
            end else if (n_ff == LAST_SLOT) begin
               state_in = lookup_ff ? ST_GIANT_STEP : ST_BABY_STEP;
            end else begin
               slot_in  = (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_BITS'(1);
               n_in     = n_ff + SLOT_BITS'(1);
               state_in = ST_PROBE_RD;
            end
         end
         ST_MM_WAIT: begin
            if (mm_rsp.done) begin
               state_in = ret_ff;
            end
         end
         ST_HIT: begin
            res_found_in = 1'b1;
            res_exp_in   = im[31:0] + {15'b0, idx_ff};
            state_in     = ST_FINISH;
         end
         // hand off to the output register once it is free
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_exp_in   = res_exp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         ret_ff        <= ST_IDLE;
         clr_ff        <= '0;
         clr_resume_ff <= 1'b0;
         epoch_ff      <= '0;
         mm_start_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         clr_ff        <= clr_in;
         clr_resume_ff <= clr_resume_in;
         epoch_ff      <= epoch_in;
         mm_start_ff   <= mm_start_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      a_ff         <= a_in;
      b_ff         <= b_in;
      p_ff         <= p_in;
      pn_ff        <= pn_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      shift_ff     <= shift_in;
      cnt_ff       <= cnt_in;
      root_ff      <= root_in;
      m_ff         <= m_in;
      j_ff         <= j_in;
      i_ff         <= i_in;
      cur_ff       <= cur_in;
      g_ff         <= g_in;
      acc_ff       <= acc_in;
      sq_ff        <= sq_in;
      e_ff         <= e_in;
      key_ff       <= key_in;
      h_ff         <= h_in;
      q_ff         <= q_in;
      diff_ff      <= diff_in;
      slot_ff      <= slot_in;
      n_ff         <= n_in;
      lookup_ff    <= lookup_in;
      idx_ff       <= idx_in;
      mm_x_ff      <= mm_x_in;
      mm_y_ff      <= mm_y_in;
      res_found_ff <= res_found_in;
      res_exp_ff   <= res_exp_in;
      rsp_found_ff <= rsp_found_in;
      rsp_exp_ff   <= rsp_exp_in;
   end

   // residue table
   dlb_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(TABLE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   // shared modular multiplier
   dlb_modmul u_modmul (
      .clock (clock),
      .reset (reset),
      .cfg   (mm_cfg),
      .req   (mm_req),
      .rsp   (mm_rsp)
   );

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_exponent = rsp_exp_ff;

endmodule

>>> rtl/core/discrete_log_bsgs_chk.sv
`timescale 1ns / 1ps
`include "discrete_log_bsgs_defines.svh"

module discrete_log_bsgs_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [31:0] rsp_exponent
);

   // one query at a time: busy right after a word is taken
   `DLB_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")

   // a miss always reports exponent zero
   `DLB_ASSERT_IMPL(a_miss_zero, rsp_valid && !rsp_found, rsp_exponent == 32'd0, "miss with exponent")

   // stalled result word holds
   `DLB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_exponent), "result changed under stall")

endmodule

bind discrete_log_bsgs discrete_log_bsgs_chk u_chk (.*);

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
   import dlb_pkg::*;

   localparam int TABLE_SLOTS = 131072;
   localparam int STALL_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 3000;

   typedef struct {
      logic        found;
      logic [31:0] exponent;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_base = '0;
   logic [31:0] req_target = '0;
   logic [31:0] req_modulus = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_found;
   logic [31:0] rsp_exponent;

   answer_type  expected_answers[$];
   int          mismatches = 0;
   int          words_sent = 0;
   int          words_checked = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_token = 0;

   // shadow residue table of the predictor
   logic [48:0] shadow_table [TABLE_SLOTS];
   bit          shadow_valid [TABLE_SLOTS];

   discrete_log_bsgs DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_base(req_base), .req_target(req_target), .req_modulus(req_modulus),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_found(rsp_found), .rsp_exponent(rsp_exponent)
   );

   always #10 clock = ~clock;

   function automatic longint unsigned mod_power(longint unsigned x, longint unsigned e,
                                                 longint unsigned p);
      longint unsigned acc;
      longint unsigned sq;
      acc = 1 % p;
      sq = x % p;
      while (e != 0) begin
         if (e[0]) acc = (acc * sq) % p;
         sq = (sq * sq) % p;
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic longint unsigned root_ceiling(longint unsigned p);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int k = 16; k >= 0; k--) begin
         t = r | (longint'(1) << k);
         if (t * t <= p) r = t;
      end
      if (r * r < p) r++;
      return r;
   endfunction

   function automatic int unsigned slot_hash(longint unsigned r);
      longint unsigned h;
      h = (r * longint'(HASH_MULT)) & 64'hFFFF_FFFF;
      return int'(h % TABLE_SLOTS);
   endfunction

   function automatic void shadow_insert(longint unsigned r, longint unsigned j);
      int unsigned s;
      s = slot_hash(r);
      for (int n = 0; n < TABLE_SLOTS; n++) begin
         if (!shadow_valid[s]) begin
            shadow_table[s] = {j[16:0], r[31:0]};
            shadow_valid[s] = 1'b1;
            return;
         end
         if (shadow_table[s][31:0] == r[31:0]) return;
         s = (s + 1) % TABLE_SLOTS;
      end
   endfunction

   function automatic bit shadow_lookup(longint unsigned r, output longint unsigned j);
      int unsigned s;
      s = slot_hash(r);
      j = 0;
      for (int n = 0; n < TABLE_SLOTS; n++) begin
         if (!shadow_valid[s]) return 1'b0;
         if (shadow_table[s][31:0] == r[31:0]) begin
            j = shadow_table[s][48:32];
            return 1'b1;
         end
         s = (s + 1) % TABLE_SLOTS;
      end
      return 1'b0;
   endfunction

   // baby-step giant-step answer for one query word
   function automatic answer_type predict_dlog(logic [31:0] base, logic [31:0] target,
                                               logic [31:0] modulus);
      answer_type      ans;
      longint unsigned p, a, b, m, cur, e, factor, d, j;
      ans.found = 1'b0;
      ans.exponent = '0;
      p = modulus;
      if (p == 0) return ans;
      a = base % p;
      b = target % p;
      if (a == 0) begin
         if (b == 0) begin
            ans.found = 1'b1;
            ans.exponent = 32'd1;
         end
         return ans;
      end
      if (b == 1) begin
         ans.found = 1'b1;
         return ans;
      end
      foreach (shadow_valid[k]) shadow_valid[k] = 1'b0;
      m = root_ceiling(p);
      cur = 1;
      for (longint unsigned i = 0; i < m; i++) begin
         shadow_insert(cur, i);
         cur = (cur * a) % p;
      end
      e = (p - 1 >= m) ? (p - 1 - m) : 0;
      factor = mod_power(a, e, p);
      d = 1;
      for (longint unsigned i = 0; i < m; i++) begin
         if (shadow_lookup((b * d) % p, j)) begin
            ans.found = 1'b1;
            ans.exponent = 32'((i * m + j) & 64'hFFFF_FFFF);
            return ans;
         end
         d = (d * factor) % p;
      end
      return ans;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // offer one query word and hold it until accepted
   task automatic send_query(logic [31:0] base, logic [31:0] target, logic [31:0] modulus);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_base <= base;
      req_target <= target;
      req_modulus <= modulus;
      do @(posedge clock); while (!req_ready);
      expected_answers.push_back(predict_dlog(base, target, modulus));
      words_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
   endtask

   function automatic bit is_prime(int unsigned n);
      if (n < 2) return 1'b0;
      for (int unsigned k = 2; k * k <= n; k++)
         if (n % k == 0) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int unsigned small_modulus(int unsigned hi);
      int unsigned p;
      p = $urandom_range(hi, 2);
      if ($urandom_range(99) < 80)
         while (!is_prime(p)) p = $urandom_range(hi, 2);
      return p;
   endfunction

   // result check, receiver idling and watchdog
   int hold_left = 0;
   int hold_seen = 0;
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               $display("MISMATCH unexpected result word at %0t", $realtime);
               mismatches++;
            end else begin
               answer_type want;
               want = expected_answers.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch("found", rsp_found, want.found);
               if (rsp_exponent !== want.exponent)
                  report_mismatch("exponent", rsp_exponent, want.exponent);
            end
            words_checked++;
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic test_special_cases;
      send_query(32'd5, 32'd3, 32'd0);                   // zero modulus
      send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);   // modulus one
      send_query(32'd3, 32'd1, 32'd2);                   // p = 2, target one
      send_query(32'd1, 32'd0, 32'd2);
      send_query(32'd0, 32'd0, 32'd7);                   // zero base, zero target
      send_query(32'd14, 32'd5, 32'd7);                  // zero base, other target
      send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_query(32'd0, 32'h8000_0001, 32'hFFFF_FFFF);
      send_query(32'h1234_5678, 32'd1, 32'hFFFF_FFFB);   // target one, wide modulus
      send_query(32'd9, 32'd8, 32'd7);                   // target reduces to one
      send_query(32'd2, 32'd3, 32'd7);                   // no solution
      send_query(32'd2, 32'd7, 32'd15);                  // composite modulus
      send_query(32'd6, 32'd4, 32'd9);
      send_query(32'd3, 32'd6, 32'd7);
      send_query(32'd5, 32'd0, 32'd11);                  // zero target, nonzero base
      drain();
   endtask

   task automatic test_large_modulus;
      send_query(32'd7, 32'd12345, 32'd65521);
      send_query(32'd5, 32'hFFF0_0001, 32'd16777213);
      drain();
   endtask

   // long receiver hold while words keep coming
   task automatic test_backpressure;
      hold_token++;
      for (int n = 0; n < 6; n++)
         send_query($urandom_range(30, 2), $urandom_range(60), 32'd31);
      drain();
   endtask

   task automatic test_random(int count);
      int unsigned p, a, x, kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(99);
         if (kind < 10) begin
            p = $urandom();
            if (kind < 5) send_query(p, $urandom(), p);
            else send_query($urandom(), (p == 1) ? 32'd1 : 32'd1 + p, p);
         end else begin
            p = small_modulus(4000);
            a = $urandom_range(p - 1, 1) + p * $urandom_range(1000);
            x = $urandom_range(4 * p);
            if (kind < 75) send_query(a, 32'(mod_power(a, x, p)) + p * $urandom_range(7), p);
            else send_query(a, $urandom(), p);
         end
      end
      drain();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 9;
      recv_idle_pct = 82;
      test_special_cases();
      test_large_modulus();
      test_backpressure();
      test_random(27);
      send_idle_pct = 82;
      recv_idle_pct = 9;
      test_random(27);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(27);
      repeat (200) @(posedge clock);
      $display("covered %0d queries: special moduli, shortcuts, no-solution and composite",
               words_sent);
      $display("cases, large moduli, a long result stall and random well-formed queries");
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> discrete_log_bsgs.f
+incdir+rtl/core
rtl/core/dlb_pkg.sv
rtl/core/dlb_ram.sv
rtl/core/dlb_modmul.sv
rtl/core/discrete_log_bsgs.sv
rtl/core/discrete_log_bsgs_chk.sv
verif/tb.sv
